### rtl/core/otp_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the Oseen tensor pair unit.
// Used by the top level, the pipelined divider and the port checker.
package otp_pkg;

   // Coordinate and result fraction bits (Q16.16 by default).
   localparam int COORD_FRAC_BITS = 16;
   // Rounding shift is ROUND_BASE plus the normalization exponent.
   localparam int ROUND_BASE = 91 - 2 * COORD_FRAC_BITS;
   // Reset value of the gain: round(2^32 / (8*pi)).
   localparam logic [31:0] SCALE_RESET = 32'd170891319;
   // Normalized magnitudes have their leading one at this bit.
   localparam int NORM_BIT = 29;
   // One quotient bit per divider stage, one root bit per square root stage.
   localparam int DIV_STAGES = 33;
   localparam int SQRT_STAGES = 31;
   // Sideband travels from the sum stage to the tensor product stage.
   localparam int SIDE_LEN = SQRT_STAGES + DIV_STAGES + 1;
   // Ratio terms wait for the gain to catch up.
   localparam int RATIO_LEN = SQRT_STAGES + 1;

   typedef enum logic [1:0] {
      PAIR_OK         = 2'd0,
      PAIR_COINCIDENT = 2'd1,
      PAIR_SATURATED  = 2'd2
   } pair_status_type;

   // Per-item flags that ride alongside the arithmetic.
   typedef struct packed {
      logic              self_pair;
      logic              zero;
      logic [2:0]        neg;
      logic signed [5:0] expo;
   } side_type;

endpackage

### rtl/core/otp_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: 64-bit dividend, 32-bit divisor, 33-bit quotient.
// One quotient bit per stage; depends on otp_pkg for the stage count, has no reset and moves only on the clock enable.
module otp_div
   import otp_pkg::*;
(
   input  logic        clock,
   input  logic        advance,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic [32:0] quotient
);

   logic [31:0] rem_ff  [1:DIV_STAGES];
   logic [32:0] quo_ff  [1:DIV_STAGES];
   logic [32:0] rest_ff [1:DIV_STAGES];
   logic [31:0] div_ff  [1:DIV_STAGES];

   logic [31:0] rem_src  [0:DIV_STAGES-1];
   logic [32:0] quo_src  [0:DIV_STAGES-1];
   logic [32:0] rest_src [0:DIV_STAGES-1];
   logic [31:0] div_src  [0:DIV_STAGES-1];

   // Stage zero takes the upper dividend bits as the first partial remainder.
   assign rem_src[0]  = {1'b0, dividend[63:33]};
   assign quo_src[0]  = '0;
   assign rest_src[0] = dividend[32:0];
   assign div_src[0]  = divisor;

   genvar j;
   generate
      for (j = 0; j < DIV_STAGES; j++) begin : g_stage
         logic [32:0] rem2;
         logic        ge;
         logic [32:0] diff;

         if (j > 0) begin : g_link
            assign rem_src[j]  = rem_ff[j];
            assign quo_src[j]  = quo_ff[j];
            assign rest_src[j] = rest_ff[j];
            assign div_src[j]  = div_ff[j];
         end

         // Bring down one dividend bit, then try a subtract.
         assign rem2 = {rem_src[j], rest_src[j][32]};
         assign ge   = rem2 >= {1'b0, div_src[j]};
         assign diff = rem2 - {1'b0, div_src[j]};

         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[j+1]  <= ge ? diff[31:0] : rem2[31:0];
               quo_ff[j+1]  <= {quo_src[j][31:0], ge};
               rest_ff[j+1] <= {rest_src[j][31:0], 1'b0};
               div_ff[j+1]  <= div_src[j];
            end
         end
      end
   endgenerate

   assign quotient = quo_ff[DIV_STAGES];

endmodule

### rtl/core/oseen_tensor_pair_unit.sv
`timescale 1ns / 1ps
// Oseen tensor pair unit: six scaled Stokeslet components of one point pair.
// Depends on otp_pkg and the pipelined divider otp_div.
//
// The unit takes one point pair per clock while not stalled and returns one
// transaction of six signed Q16.16 components and a status. The pipeline is
// built around the bit-per-stage square root (31 stages) followed by the
// bit-per-stage reciprocal divider (33 stages), with the normalization,
// multiply and rounding stages around them. A stalled result freezes the
// whole pipeline, so req_stall follows rsp_stall while a result is waiting.
// The gain resets to 1/(8*pi) and is written through csr_we and csr_wdata;
// the user must write it only while no pair is in flight (not enforced).
module oseen_tensor_pair_unit
   import otp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [31:0] req_a_x,
   input  logic signed [31:0] req_a_y,
   input  logic signed [31:0] req_a_z,
   input  logic signed [31:0] req_b_x,
   input  logic signed [31:0] req_b_y,
   input  logic signed [31:0] req_b_z,
   input  logic        req_self_pair,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_out_xx,
   output logic signed [31:0] rsp_out_xy,
   output logic signed [31:0] rsp_out_xz,
   output logic signed [31:0] rsp_out_yy,
   output logic signed [31:0] rsp_out_yz,
   output logic signed [31:0] rsp_out_zz,
   output logic [1:0]  rsp_pair_status
);

   logic        advance;
   logic [31:0] scale_ff;
   logic        rsp_valid_ff;

   // The whole pipeline moves unless the output transaction is held.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Gain register.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_we) begin
         scale_ff <= csr_wdata;
      end
   end

   // Stage 1: coordinate differences.
   logic               v1_ff, self1_ff;
   logic signed [32:0] diff1_ff [3];
   logic signed [32:0] diff1_in [3];

   assign diff1_in[0] = {req_a_x[31], req_a_x} - {req_b_x[31], req_b_x};
   assign diff1_in[1] = {req_a_y[31], req_a_y} - {req_b_y[31], req_b_y};
   assign diff1_in[2] = {req_a_z[31], req_a_z} - {req_b_z[31], req_b_z};

   always_ff @(posedge clock) begin
      if (advance) begin
         diff1_ff <= diff1_in;
         self1_ff <= req_self_pair;
      end
   end

   // Stage 2: magnitudes and signs.
   logic        v2_ff, self2_ff;
   logic [32:0] mag2_ff [3];
   logic [2:0]  neg2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            neg2_ff[i] <= diff1_ff[i][32];
            mag2_ff[i] <= diff1_ff[i][32] ? 33'(-diff1_ff[i]) : 33'(diff1_ff[i]);
         end
         self2_ff <= self1_ff;
      end
   end

   // Stage 3: largest magnitude and the position of its leading one.
   logic        v3_ff, self3_ff, zero3_ff;
   logic [32:0] mag3_ff [3];
   logic [2:0]  neg3_ff;
   logic [5:0]  lead3_ff;
   logic [32:0] mx3_in;
   logic [5:0]  lead3_in;

   always_comb begin
      mx3_in = mag2_ff[0];
      if (mag2_ff[1] > mx3_in) mx3_in = mag2_ff[1];
      if (mag2_ff[2] > mx3_in) mx3_in = mag2_ff[2];
      lead3_in = '0;
      for (int i = 0; i < 33; i++) begin
         if (mx3_in[i]) lead3_in = 6'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag3_ff  <= mag2_ff;
         neg3_ff  <= neg2_ff;
         self3_ff <= self2_ff;
         zero3_ff <= (mx3_in == '0);
         lead3_ff <= lead3_in;
      end
   end

   // Stage 4: shift all magnitudes together so the largest has its top bit at 29.
   logic        v4_ff;
   logic [29:0] m4_ff [3];
   side_type    side4_ff;
   logic [29:0] m4_in [3];
   logic signed [6:0] e4_in;

   assign e4_in = $signed({1'b0, lead3_ff}) - 7'(NORM_BIT);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (lead3_ff > 6'(NORM_BIT)) begin
            m4_in[i] = 30'(mag3_ff[i] >> (lead3_ff - 6'(NORM_BIT)));
         end else begin
            m4_in[i] = 30'(mag3_ff[i] << (6'(NORM_BIT) - lead3_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m4_ff              <= m4_in;
         side4_ff.self_pair <= self3_ff;
         side4_ff.zero      <= zero3_ff;
         side4_ff.neg       <= neg3_ff;
         side4_ff.expo      <= 6'(e4_in);
      end
   end

   // Stage 5: squares and cross products.
   logic        v5_ff;
   logic [59:0] prod5_ff [6];
   side_type    side5_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod5_ff[0] <= 60'(m4_ff[0]) * 60'(m4_ff[0]);
         prod5_ff[1] <= 60'(m4_ff[0]) * 60'(m4_ff[1]);
         prod5_ff[2] <= 60'(m4_ff[0]) * 60'(m4_ff[2]);
         prod5_ff[3] <= 60'(m4_ff[1]) * 60'(m4_ff[1]);
         prod5_ff[4] <= 60'(m4_ff[1]) * 60'(m4_ff[2]);
         prod5_ff[5] <= 60'(m4_ff[2]) * 60'(m4_ff[2]);
         side5_ff    <= side4_ff;
      end
   end

   // Stage 6: squared distance of the normalized vector.
   logic        v6_ff;
   logic [61:0] sum6_ff;
   logic [59:0] prod6_ff [6];
   side_type    side6_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         sum6_ff  <= 62'(prod5_ff[0]) + 62'(prod5_ff[3]) + 62'(prod5_ff[5]);
         prod6_ff <= prod5_ff;
         side6_ff <= side5_ff;
      end
   end

   // Ratio terms: each product over the top bits of the squared distance.
   logic [32:0] ratio_q [6];

   genvar c;
   generate
      for (c = 0; c < 6; c++) begin : g_ratio
         otp_div u_div (
            .clock    (clock),
            .advance  (advance),
            .dividend ({4'b0, prod6_ff[c]}),
            .divisor  (sum6_ff[61:30]),
            .quotient (ratio_q[c])
         );
      end
   endgenerate

   // Square root, one root bit per stage.
   logic [32:0] sq_rem_ff  [1:SQRT_STAGES];
   logic [30:0] sq_root_ff [1:SQRT_STAGES];
   logic [61:0] sq_rest_ff [1:SQRT_STAGES];
   logic [32:0] sq_rem_src  [0:SQRT_STAGES-1];
   logic [30:0] sq_root_src [0:SQRT_STAGES-1];
   logic [61:0] sq_rest_src [0:SQRT_STAGES-1];

   assign sq_rem_src[0]  = '0;
   assign sq_root_src[0] = '0;
   assign sq_rest_src[0] = sum6_ff;

   genvar j;
   generate
      for (j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
         logic [34:0] rem2;
         logic [34:0] trial;
         logic        ge;
         logic [34:0] diff;

         if (j > 0) begin : g_link
            assign sq_rem_src[j]  = sq_rem_ff[j];
            assign sq_root_src[j] = sq_root_ff[j];
            assign sq_rest_src[j] = sq_rest_ff[j];
         end

         assign rem2  = {sq_rem_src[j][32:0], sq_rest_src[j][61:60]};
         assign trial = {2'b0, sq_root_src[j], 2'b01};
         assign ge    = rem2 >= trial;
         assign diff  = rem2 - trial;

         always_ff @(posedge clock) begin
            if (advance) begin
               sq_rem_ff[j+1]  <= ge ? diff[32:0] : rem2[32:0];
               sq_root_ff[j+1] <= {sq_root_src[j][29:0], ge};
               sq_rest_ff[j+1] <= {sq_rest_src[j][59:0], 2'b00};
            end
         end
      end
   endgenerate

   // Reciprocal of the root: 2^61 / R.
   logic [32:0] inv_q;

   otp_div u_inv (
      .clock    (clock),
      .advance  (advance),
      .dividend (64'd1 << 61),
      .divisor  ({1'b0, sq_root_ff[SQRT_STAGES]}),
      .quotient (inv_q)
   );

   // Ratio delay line; the diagonal terms pick up the unit term on entry.
   logic [5:0][32:0] ratio_ff [1:RATIO_LEN];
   logic [5:0][32:0] ratio_in;

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         ratio_in[i] = ratio_q[i];
      end
      ratio_in[0] = ratio_q[0] + (33'd1 << 30);
      ratio_in[3] = ratio_q[3] + (33'd1 << 30);
      ratio_in[5] = ratio_q[5] + (33'd1 << 30);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ratio_ff[1] <= ratio_in;
         for (int i = 2; i <= RATIO_LEN; i++) begin
            ratio_ff[i] <= ratio_ff[i-1];
         end
      end
   end

   // Sideband and valid delay line across the root and reciprocal.
   side_type side_ff [1:SIDE_LEN];
   logic     vd_ff   [1:SIDE_LEN];

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[1] <= side6_ff;
         for (int i = 2; i <= SIDE_LEN; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Gain times reciprocal lines up with the last sideband stage.
   logic [31:0] t_ff;
   logic [64:0] t_prod;

   assign t_prod = 65'(scale_ff) * 65'(inv_q);

   always_ff @(posedge clock) begin
      if (advance) begin
         t_ff <= t_prod[63:32];
      end
   end

   // Stage P: tensor products and the rounding shift count.
   logic        vp_ff;
   logic [63:0] p_ff [6];
   logic [6:0]  kp_ff;
   side_type    sidep_ff;
   logic signed [7:0] kp_in;

   assign kp_in = 8'(ROUND_BASE) + 8'(side_ff[SIDE_LEN].expo);

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 6; i++) begin
            p_ff[i] <= 64'(64'(t_ff) * 64'(ratio_ff[RATIO_LEN][i]));
         end
         kp_ff    <= 7'(kp_in);
         sidep_ff <= side_ff[SIDE_LEN];
      end
   end

   // Stage R: add the rounding half.
   logic        vr_ff;
   logic [63:0] rs_ff [6];
   logic [6:0]  kr_ff;
   side_type    sider_ff;
   logic [63:0] half_in;

   assign half_in = (kp_ff >= 7'd64) ? '0 : (64'd1 << (kp_ff - 7'd1));

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 6; i++) begin
            rs_ff[i] <= p_ff[i] + half_in;
         end
         kr_ff    <= kp_ff;
         sider_ff <= sidep_ff;
      end
   end

   // Stage M: scale down to the output format.
   logic        vm_ff;
   logic [63:0] mm_ff [6];
   side_type    sidem_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 6; i++) begin
            mm_ff[i] <= (kr_ff >= 7'd64) ? '0 : (rs_ff[i] >> kr_ff[5:0]);
         end
         sidem_ff <= sider_ff;
      end
   end

   // Output stage: sign, saturation and the special cases.
   logic [31:0]     out_in [6];
   logic [5:0]      sat_in;
   logic [5:0]      sneg;
   pair_status_type status_in;
   logic [31:0]     out_ff [6];
   pair_status_type status_ff;

   // Off-diagonal signs: yz at bit 4, xz at bit 2, xy at bit 1.
   assign sneg = {1'b0, sidem_ff.neg[1] ^ sidem_ff.neg[2], 1'b0,
                  sidem_ff.neg[0] ^ sidem_ff.neg[2], sidem_ff.neg[0] ^ sidem_ff.neg[1], 1'b0};

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         if (!sneg[i]) begin
            sat_in[i] = mm_ff[i] > 64'h7FFF_FFFF;
            out_in[i] = sat_in[i] ? 32'h7FFF_FFFF : mm_ff[i][31:0];
         end else begin
            sat_in[i] = mm_ff[i] > 64'h8000_0000;
            out_in[i] = sat_in[i] ? 32'h8000_0000 : 32'(32'd0 - mm_ff[i][31:0]);
         end
      end
      status_in = (sat_in != '0) ? PAIR_SATURATED : PAIR_OK;
      if (sidem_ff.self_pair) begin
         for (int i = 0; i < 6; i++) out_in[i] = '0;
         status_in = PAIR_OK;
      end else if (sidem_ff.zero) begin
         for (int i = 0; i < 6; i++) out_in[i] = '0;
         status_in = PAIR_COINCIDENT;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff    <= out_in;
         status_ff <= status_in;
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         for (int i = 1; i <= SIDE_LEN; i++) vd_ff[i] <= 1'b0;
         vp_ff        <= 1'b0;
         vr_ff        <= 1'b0;
         vm_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff    <= req_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         v5_ff    <= v4_ff;
         v6_ff    <= v5_ff;
         vd_ff[1] <= v6_ff;
         for (int i = 2; i <= SIDE_LEN; i++) vd_ff[i] <= vd_ff[i-1];
         vp_ff        <= vd_ff[SIDE_LEN];
         vr_ff        <= vp_ff;
         vm_ff        <= vr_ff;
         rsp_valid_ff <= vm_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_xx      = out_ff[0];
   assign rsp_out_xy      = out_ff[1];
   assign rsp_out_xz      = out_ff[2];
   assign rsp_out_yy      = out_ff[3];
   assign rsp_out_yz      = out_ff[4];
   assign rsp_out_zz      = out_ff[5];
   assign rsp_pair_status = status_ff;

endmodule

### rtl/core/otp_port_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the Oseen tensor pair unit, bound to the top level.
// Depends on otp_pkg for the status codes.
module otp_port_checker
   import otp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_out_xx,
   input logic [31:0] rsp_out_xy,
   input logic [31:0] rsp_out_xz,
   input logic [31:0] rsp_out_yy,
   input logic [31:0] rsp_out_yz,
   input logic [31:0] rsp_out_zz,
   input logic [1:0]  rsp_pair_status
);

   // Reset empties the pipeline.
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A held result transaction stays valid and keeps its xy component and status.
   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_xy)
                                 && $stable(rsp_pair_status))
      else $error("held result changed");

   // The input only waits on a held result.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

   // Coincident points give an all-zero tensor.
   a_coincident_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pair_status == PAIR_COINCIDENT |->
         rsp_out_xx == '0 && rsp_out_xy == '0 && rsp_out_xz == '0 &&
         rsp_out_yy == '0 && rsp_out_yz == '0 && rsp_out_zz == '0)
      else $error("coincident pair with nonzero tensor");

   // A saturated status comes with at least one clamped component.
   a_saturated_clamp : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pair_status == PAIR_SATURATED |->
         rsp_out_xx == 32'h7FFF_FFFF || rsp_out_xy == 32'h7FFF_FFFF ||
         rsp_out_xz == 32'h7FFF_FFFF || rsp_out_yy == 32'h7FFF_FFFF ||
         rsp_out_yz == 32'h7FFF_FFFF || rsp_out_zz == 32'h7FFF_FFFF ||
         rsp_out_xy == 32'h8000_0000 || rsp_out_xz == 32'h8000_0000 ||
         rsp_out_yz == 32'h8000_0000)
      else $error("saturated status without a clamped component");

endmodule

bind oseen_tensor_pair_unit otp_port_checker u_port_checker (.*);
